// ----- sv/mmd_pkg.sv -----
// Shared constants, codes and control/status types for the mailbox message deque.
package mmd_pkg;

    localparam int SLOT_COUNT   = 16;
    localparam int MESSAGE_BITS = 32;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int CFG_W = 5;
    localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ACT_W = 2;
    localparam int ST_W  = 2;
    localparam int OUT_MSG_W = 32;
    localparam int FILL_W    = 5;

    localparam logic [CFG_W-1:0] MAX_COUNT_RESET = CFG_W'(16);

    localparam logic [ACT_W-1:0] ACT_TAKE       = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POST_BACK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POST_FRONT = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FLUSH      = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } mmd_cmd_t;

    typedef struct packed {
        logic out_free;
    } mmd_stat_t;

endpackage

// ----- sv/mailbox_message_deque.sv -----
// Top level of the mailbox message deque: sequencer plus ring datapath.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   input    | in_valid / in_ready   | action, message
//   result   | out_valid / out_ready | status, taken_message, fill_count
//   config   | cfg_valid / cfg_ready | cfg_data (max_count)
//
// Each input word passes through capture, execute (slot write or
// registered slot read, pointer and count update) and load into the result
// register. A new word is taken as soon as the sequencer is back in idle,
// even while the previous result still sits unclaimed in the result register.
// A stalled result holds the sequencer in its load step until out_ready.
// Reset clears pointers, fill count and the result valid, and sets the
// capacity to 16; slot contents stay undefined until written.
// Configuration writes are always accepted (cfg_ready is tied high).
module mailbox_message_deque (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mmd_pkg::ACT_W-1:0]          action,
    input  logic [mmd_pkg::MESSAGE_BITS-1:0]   message,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mmd_pkg::ST_W-1:0]           status,
    output logic [mmd_pkg::OUT_MSG_W-1:0]      taken_message,
    output logic [mmd_pkg::FILL_W-1:0]         fill_count,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mmd_pkg::CFG_W-1:0]          cfg_data
);
    import mmd_pkg::*;

    mmd_cmd_t  cmd;
    mmd_stat_t stat;

    // capacity register never stalls a write
    assign cfg_ready = 1'b1;

    mmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mmd_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .action        (action),
        .message       (message),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .taken_message (taken_message),
        .fill_count    (fill_count)
    );

endmodule

// ----- sv/mmd_ctrl.sv -----
// Sequencer for the mailbox: capture a word, execute it, load the result register.
module mmd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mmd_pkg::mmd_stat_t stat,
    output mmd_pkg::mmd_cmd_t  cmd
);
    import mmd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                // hold until the result register can take the word
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/mmd_datapath.sv -----
// Ring storage, pointers, fill count, capacity register and result register.
module mmd_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mmd_pkg::mmd_cmd_t                  cmd,
    output mmd_pkg::mmd_stat_t                 stat,
    input  logic                               cfg_valid,
    input  logic [mmd_pkg::CFG_W-1:0]          cfg_data,
    input  logic [mmd_pkg::ACT_W-1:0]          action,
    input  logic [mmd_pkg::MESSAGE_BITS-1:0]   message,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mmd_pkg::ST_W-1:0]           status,
    output logic [mmd_pkg::OUT_MSG_W-1:0]      taken_message,
    output logic [mmd_pkg::FILL_W-1:0]         fill_count
);
    import mmd_pkg::*;

    logic [MESSAGE_BITS-1:0] slot_mem [SLOT_COUNT];

    logic [CFG_W-1:0]        max_count_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [IDX_W-1:0]        rd_idx_next;
    logic [IDX_W-1:0]        wr_idx_reg;
    logic [IDX_W-1:0]        wr_idx_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;

    logic [ACT_W-1:0]        act_reg;
    logic [MESSAGE_BITS-1:0] msg_reg;
    logic [ST_W-1:0]         status_reg;
    logic [ST_W-1:0]         status_next;
    logic [MESSAGE_BITS-1:0] rd_data_reg;
    logic [ST_W-1:0]         out_status_reg;
    logic [OUT_MSG_W-1:0]    out_taken_reg;
    logic [FILL_W-1:0]       out_fill_reg;

    logic [CAP_W-1:0]        cap;
    logic [CAP_W-1:0]        max_ext;
    logic [CAP_W-1:0]        rd_step;
    logic [CAP_W-1:0]        wr_step;
    logic                    box_full;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [MESSAGE_BITS-1:0] taken_word;

    assign max_ext = CAP_W'(max_count_reg);
    assign rd_step = CAP_W'(rd_idx_reg) + CAP_W'(1);
    assign wr_step = CAP_W'(wr_idx_reg) + CAP_W'(1);
    assign box_full = (CAP_W'(count_reg) >= cap);

    always_comb
    begin
        if (max_ext == '0)
            cap = CAP_W'(1);
        else if (max_ext > CAP_W'(SLOT_COUNT))
            cap = CAP_W'(SLOT_COUNT);
        else
            cap = max_ext;
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        mem_we      = 1'b0;
        mem_waddr   = wr_idx_reg;
        unique case (act_reg)
            ACT_TAKE:
            begin
                if (count_reg != '0)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    rd_idx_next = (rd_step >= cap) ? '0 : rd_step[IDX_W-1:0];
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            ACT_POST_BACK, ACT_POST_FRONT:
            begin
                if (box_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (act_reg == ACT_POST_FRONT)
                    begin
                        // step the read pointer back one slot, wrapping below zero
                        if (rd_idx_reg == '0)
                            rd_idx_next = IDX_W'(cap - CAP_W'(1));
                        else
                            rd_idx_next = rd_idx_reg - IDX_W'(1);
                        mem_waddr = rd_idx_next;
                    end
                    else
                    begin
                        wr_idx_next = (wr_step >= cap) ? '0 : wr_step[IDX_W-1:0];
                    end
                end
            end
            ACT_FLUSH:
            begin
                rd_idx_next = '0;
                wr_idx_next = '0;
                count_next  = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg <= MAX_COUNT_RESET;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                max_count_reg <= cfg_data;
            if (cmd.execute)
            begin
                rd_idx_reg <= rd_idx_next;
                wr_idx_reg <= wr_idx_next;
                count_reg  <= count_next;
            end
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && mem_we)
            slot_mem[mem_waddr] <= msg_reg;
        if (cmd.execute)
            rd_data_reg <= slot_mem[rd_idx_reg];
    end

    assign taken_word = ((act_reg == ACT_TAKE) && (status_reg == ST_OK)) ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            msg_reg <= message;
        end
        if (cmd.execute)
            status_reg <= status_next;
        if (cmd.load)
        begin
            out_status_reg <= status_reg;
            out_taken_reg  <= OUT_MSG_W'(taken_word);
            out_fill_reg   <= FILL_W'(count_reg);
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign taken_message  = out_taken_reg;
    assign fill_count     = out_fill_reg;

endmodule

// ----- sv/mmd_checker.sv -----
// Port-level checks for the mailbox message deque, bound to the top level.
module mmd_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [mmd_pkg::ST_W-1:0]           status,
    input  logic [mmd_pkg::OUT_MSG_W-1:0]      taken_message,
    input  logic [mmd_pkg::FILL_W-1:0]         fill_count
);
    import mmd_pkg::*;

    // a stalled result word holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(taken_message) && $stable(fill_count))
        else $error("result word changed while stalled");

    // only a successful take carries a message
    a_taken_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> taken_message == '0)
        else $error("failed item carries a message");

    // an empty report leaves the box empty
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> fill_count == '0)
        else $error("empty report with messages held");

    // a full report means at least one message is held
    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> fill_count != '0)
        else $error("full report with an empty box");

    // status never takes the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_EMPTY || status == ST_FULL)
        else $error("result status out of range");

endmodule

bind mailbox_message_deque mmd_checker u_mmd_checker (.*);

// ----- dv/tb.sv -----
// Self-checking testbench for the mailbox message deque: random deque traffic checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmd_pkg::*;

    // Show this many mismatches in full, then only count them.
    localparam int MISMATCH_SHOWN = 10;
    // Stop the run after this many cycles in which no word moves on any channel.
    localparam int STALL_LIMIT    = 5000;
    // Minimum number of random requests in each capacity phase.
    localparam int PHASE_ITEMS    = 60;
    localparam int PHASE_COUNT    = 8;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [MESSAGE_BITS-1:0] message;
    } request_t;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [OUT_MSG_W-1:0] taken;
        logic [FILL_W-1:0]    fill;
    } reply_t;

    // Initialize every block input so that nothing floats before reset is released.
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [ACT_W-1:0]        action = ACT_TAKE;
    logic [MESSAGE_BITS-1:0] message = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [ST_W-1:0]         status;
    logic [OUT_MSG_W-1:0]    taken_message;
    logic [FILL_W-1:0]       fill_count;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data = '0;

    mailbox_message_deque dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .message       (message),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .taken_message (taken_message),
        .fill_count    (fill_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Requests waiting for the driver, and replies predicted for accepted requests, oldest first.
    request_t queued_requests[$];
    reply_t   predicted_replies[$];
    reply_t   oldest_reply;

    // Idle knobs, in percent: sender gap chance and receiver stall chance per cycle.
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned requests_accepted = 0;
    int unsigned replies_seen      = 0;
    int unsigned config_writes     = 0;
    int unsigned ok_count          = 0;
    int unsigned empty_count       = 0;
    int unsigned full_count        = 0;
    int unsigned flush_count       = 0;
    int unsigned mismatch_count    = 0;
    int unsigned quiet_cycles      = 0;

    // Predictor state: its own copy of the ring, pointers, count and the raw capacity register.
    logic [MESSAGE_BITS-1:0] box_slot [SLOT_COUNT];
    logic [IDX_W-1:0]        box_rd    = '0;
    logic [IDX_W-1:0]        box_wr    = '0;
    logic [CNT_W-1:0]        box_held  = '0;
    logic [CFG_W-1:0]        box_limit = MAX_COUNT_RESET;

    // Map the raw register to the wrap point: zero acts as one, anything past the ring as full size.
    function automatic int unsigned ring_capacity();
        if (box_limit == '0)
            return 1;
        if (box_limit > SLOT_COUNT)
            return SLOT_COUNT;
        return box_limit;
    endfunction

    // Apply one request to the predictor state and return the reply the block owes for it.
    function automatic reply_t apply_mailbox_action(logic [ACT_W-1:0] act,
                                                    logic [MESSAGE_BITS-1:0] msg);
        reply_t      r;
        int unsigned cap;
        int unsigned step_to;
        cap = ring_capacity();
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_TAKE:
            begin
                if (box_held != '0)
                begin
                    box_held = box_held - 1'b1;
                    r.taken = OUT_MSG_W'(box_slot[box_rd]);
                    step_to = box_rd + 1;
                    box_rd = (step_to >= cap) ? '0 : IDX_W'(step_to);
                end
                else
                    r.status = ST_EMPTY;
            end
            ACT_POST_BACK, ACT_POST_FRONT:
            begin
                if (box_held >= cap)
                    r.status = ST_FULL;
                else
                begin
                    if (act == ACT_POST_FRONT)
                    begin
                        // Step the read pointer back; from slot zero wrap to the top slot in use.
                        box_rd = (box_rd == '0) ? IDX_W'(cap - 1) : box_rd - 1'b1;
                        box_slot[box_rd] = msg;
                    end
                    else
                    begin
                        box_slot[box_wr] = msg;
                        step_to = box_wr + 1;
                        box_wr = (step_to >= cap) ? '0 : IDX_W'(step_to);
                    end
                    box_held = box_held + 1'b1;
                end
            end
            ACT_FLUSH:
            begin
                // Flush clears the pointers and count only; slot contents survive.
                box_rd = '0;
                box_wr = '0;
                box_held = '0;
            end
        endcase
        r.fill = FILL_W'(box_held);
        return r;
    endfunction

    // Driver: predict the word accepted at this edge, then hold it or present the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted_replies.push_back(apply_mailbox_action(action, message));
                requests_accepted++;
            end
            // Hold valid and payload while a word is presented and not yet taken.
            if (!in_valid || in_ready)
            begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    action   <= queued_requests[0].action;
                    message  <= queued_requests[0].message;
                    in_valid <= 1'b1;
                    void'(queued_requests.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check the reply word taken at this edge, then pick the next stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                replies_seen++;
                case (status)
                    ST_OK:    ok_count++;
                    ST_EMPTY: empty_count++;
                    ST_FULL:  full_count++;
                    default:  ;
                endcase
                if (predicted_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MISMATCH_SHOWN)
                        $display("%0t: reply with none predicted: status %0d taken %h fill %0d",
                                 $realtime, status, taken_message, fill_count);
                end
                else
                begin
                    oldest_reply = predicted_replies.pop_front();
                    if (status !== oldest_reply.status || taken_message !== oldest_reply.taken
                        || fill_count !== oldest_reply.fill)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MISMATCH_SHOWN)
                            $display({"%0t: reply mismatch: expected status %0d taken %h fill %0d,",
                                      " got status %0d taken %h fill %0d"},
                                     $realtime, oldest_reply.status, oldest_reply.taken,
                                     oldest_reply.fill, status, taken_message, fill_count);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run once no word has moved on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d replies still outstanding",
                         $realtime, STALL_LIMIT, predicted_replies.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic queue_request(logic [ACT_W-1:0] act, logic [MESSAGE_BITS-1:0] msg);
        request_t req;
        req.action  = act;
        req.message = msg;
        if (act == ACT_FLUSH)
            flush_count++;
        queued_requests.push_back(req);
    endtask

    // Advance until every queued request is taken and every predicted reply has arrived.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (queued_requests.size() != 0 || in_valid || predicted_replies.size() != 0);
    endtask

    // Capacity plan for the random phases: extremes, out-of-range values and a random middle one.
    int unsigned capacity_plan [PHASE_COUNT] = '{4, 0, 31, 1, 17, 16, 8, 11};

    initial
    begin
        int unsigned      queued;
        int unsigned      burst;
        int unsigned      bias;
        int unsigned      pick;
        int unsigned      take_cut;
        int unsigned      back_cut;
        logic [ACT_W-1:0] act;
        logic [MESSAGE_BITS-1:0] msg;

        capacity_plan[6] = $urandom_range(2, 15);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset capacity of 16. Take from the empty box first, then fill
        // every slot with extreme patterns so no later take can land on a never-written slot.
        queue_request(ACT_TAKE, '0);
        queue_request(ACT_POST_BACK, '0);
        queue_request(ACT_POST_BACK, '1);
        queue_request(ACT_POST_BACK, 32'h0000_0001);
        queue_request(ACT_POST_BACK, 32'h8000_0000);
        queue_request(ACT_POST_BACK, 32'hAAAA_AAAA);
        queue_request(ACT_POST_BACK, 32'h5555_5555);
        repeat (10) queue_request(ACT_POST_BACK, $urandom);
        // Box is full: both kinds of post must bounce without changing anything.
        queue_request(ACT_POST_BACK, $urandom);
        queue_request(ACT_POST_FRONT, $urandom);
        // Free one slot, refill it from the front, then drain a little.
        queue_request(ACT_TAKE, '0);
        queue_request(ACT_POST_FRONT, 32'hDEAD_0001);
        queue_request(ACT_TAKE, '1);
        queue_request(ACT_TAKE, '0);
        // Flush a populated box, then post at the front from read index zero to force the wrap.
        queue_request(ACT_FLUSH, $urandom);
        queue_request(ACT_POST_FRONT, 32'h0F0F_F0F0);
        queue_request(ACT_TAKE, '0);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            // Box is idle here but may still hold messages, so a lower capacity can start
            // with the fill at or above the new limit.
            @(posedge clk);
            cfg_data  <= CFG_W'(capacity_plan[p]);
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            box_limit = cfg_data;
            config_writes++;
            cfg_valid <= 1'b0;

            // Cycle through the idle modes: none, sender gaps, receiver stalls, both.
            case (p % 4)
                0:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct   = 69;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 69;
                end
                default:
                begin
                    send_gap_pct   = 28;
                    recv_stall_pct = 28;
                end
            endcase

            // Random traffic in bursts leaning toward filling, draining or a mix,
            // so the box swings between full and empty.
            queued = 0;
            while (queued < PHASE_ITEMS)
            begin
                burst = $urandom_range(4, 24);
                bias  = $urandom_range(2);
                case (bias)
                    0:
                    begin
                        take_cut = 20;
                        back_cut = 65;
                    end
                    1:
                    begin
                        take_cut = 75;
                        back_cut = 90;
                    end
                    default:
                    begin
                        take_cut = 40;
                        back_cut = 75;
                    end
                endcase
                repeat (burst)
                begin
                    pick = $urandom_range(99);
                    if (pick < 3)
                        act = ACT_FLUSH;
                    else if (pick < take_cut)
                        act = ACT_TAKE;
                    else if (pick < back_cut)
                        act = ACT_POST_BACK;
                    else
                        act = ACT_POST_FRONT;
                    case ($urandom_range(7))
                        0:       msg = '0;
                        1:       msg = '1;
                        default: msg = $urandom;
                    endcase
                    queue_request(act, msg);
                    queued++;
                end
            end
            wait_drained();
        end

        // Let any stray reply show up before judging the run.
        repeat (8) @(posedge clk);
        $display("covered %0d requests and %0d replies across %0d capacity writes",
                 requests_accepted, replies_seen, config_writes);
        $display("outcomes: %0d ok, %0d take on empty, %0d post on full, %0d flushes; %0d mismatches",
                 ok_count, empty_count, full_count, flush_count, mismatch_count);
        if (mismatch_count == 0 && predicted_replies.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/mmd_pkg.sv
sv/mmd_ctrl.sv
sv/mmd_datapath.sv
sv/mailbox_message_deque.sv
sv/mmd_checker.sv
dv/tb.sv
